[rtl/core/light_level_dimmer_ramp_assert.svh]
// Assertion macros used by the checker file of the dimmer ramp.
`ifndef LIGHT_LEVEL_DIMMER_RAMP_ASSERT_SVH
`define LIGHT_LEVEL_DIMMER_RAMP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define LLDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define LLDR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[rtl/core/lldr_pkg.sv]
// Shared widths, constants and types of the dimmer ramp.
package lldr_pkg;

    localparam int PCT_W     = 7;
    localparam int RAW_W     = 12;
    localparam int OFS_W     = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 7;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [RAW_W-1:0] RAW_FULL = 12'd4095;

    localparam logic [CFG_IDX_W-1:0] CFG_HYST_BAND = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ON   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_OFF  = 4'd3;

    localparam logic [PCT_W-1:0] RST_HYST_BAND = 7'd3;
    localparam logic [PCT_W-1:0] RST_RAMP_STEP = 7'd2;
    localparam logic [PCT_W-1:0] RST_STEP_ON   = 7'd10;
    localparam logic [PCT_W-1:0] RST_STEP_OFF  = 7'd10;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    typedef struct packed {
        logic [PCT_W-1:0] hyst_band;
        logic [PCT_W-1:0] ramp_step;
        logic [PCT_W-1:0] step_on;
        logic [PCT_W-1:0] step_off;
    } cfg_t;

    typedef struct packed {
        logic [PCT_W-1:0] auto_pct;
        logic [PCT_W-1:0] target_pct;
    } front_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

[rtl/core/lldr_cfg.sv]
// Configuration register file of the dimmer ramp.
module lldr_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lldr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lldr_pkg::CFG_DAT_W-1:0] cfg_data,
    output lldr_pkg::cfg_t                 cfg
);
    import lldr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HYST_BAND: cfg_next.hyst_band = cfg_data[PCT_W-1:0];
                CFG_RAMP_STEP: cfg_next.ramp_step = cfg_data[PCT_W-1:0];
                CFG_STEP_ON:   cfg_next.step_on   = cfg_data[PCT_W-1:0];
                CFG_STEP_OFF:  cfg_next.step_off  = cfg_data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hyst_band <= RST_HYST_BAND;
            cfg_reg.ramp_step <= RST_RAMP_STEP;
            cfg_reg.step_on   <= RST_STEP_ON;
            cfg_reg.step_off  <= RST_STEP_OFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/lldr_front.sv]
// Front stage: automatic level, offset, clamp and gating of each reading.
module lldr_front (
    input  logic [lldr_pkg::RAW_W-1:0] light_raw,
    input  logic                       light_on,
    input  logic                       user_present,
    input  logic [lldr_pkg::OFS_W-1:0] user_offset,
    output lldr_pkg::front_item_t      item
);
    import lldr_pkg::*;

    localparam int PROD_W = RAW_W + PCT_W;

    logic [PROD_W-1:0]  prod;
    logic [PCT_W-1:0]   quot_lo;
    logic [RAW_W:0]     rem_est;
    logic [PCT_W-1:0]   scaled;
    logic [PCT_W-1:0]   auto_pct;
    logic signed [9:0]  sum;
    logic [PCT_W-1:0]   clamped;

    // Division by 4095 uses x = q*4096 + r = q*4095 + (q + r).
    always_comb begin
        prod     = PROD_W'({light_raw, 6'b0}) + PROD_W'({light_raw, 5'b0})
                 + PROD_W'({light_raw, 2'b0});
        quot_lo  = prod[PROD_W-1:RAW_W];
        rem_est  = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(quot_lo);
        scaled   = quot_lo + PCT_W'(rem_est >= {1'b0, RAW_FULL});
        auto_pct = PCT_FULL - scaled;
        sum      = $signed({3'b000, auto_pct})
                 + $signed({{2{user_offset[OFS_W-1]}}, user_offset});
        if (sum <= 10'sd0) begin
            clamped = '0;
        end else if (sum >= $signed({3'b000, PCT_FULL})) begin
            clamped = PCT_FULL;
        end else begin
            clamped = sum[PCT_W-1:0];
        end
        item.auto_pct   = auto_pct;
        item.target_pct = (light_on && user_present) ? clamped : '0;
    end

endmodule

[rtl/core/lldr_fifo.sv]
// Short queue between the front and back stages.
module lldr_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lldr_pkg::front_item_t push_data,
    input  logic                  pop,
    output lldr_pkg::front_item_t pop_data,
    output lldr_pkg::fifo_status_t status
);
    import lldr_pkg::*;

    front_item_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_next;
    logic [FIFO_AW:0]       count_reg;
    logic [FIFO_AW:0]       count_next;
    logic                   do_push;
    logic                   do_pop;

    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/lldr_back.sv]
// Back stage: hysteresis hold, slew ramp and the result register.
module lldr_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lldr_pkg::cfg_t             cfg,
    input  lldr_pkg::front_item_t      item,
    input  logic                       item_avail,
    output logic                       item_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lldr_pkg::PCT_W-1:0] m_lamp_level,
    output logic [lldr_pkg::PCT_W-1:0] m_auto_level,
    output logic [lldr_pkg::PCT_W-1:0] m_goal_level,
    output logic [lldr_pkg::PCT_W-1:0] m_held_percent
);
    import lldr_pkg::*;

    logic             hold_ready_reg;
    logic [PCT_W-1:0] held_level_reg;
    logic             ramp_ready_reg;
    logic [PCT_W-1:0] ramp_level_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [PCT_W-1:0] out_pct_reg;
    logic [PCT_W-1:0] auto_pct_reg;
    logic [PCT_W-1:0] target_pct_reg;
    logic [PCT_W-1:0] held_pct_reg;

    logic [PCT_W-1:0] tgt;
    logic [PCT_W-1:0] diff;
    logic [PCT_W-1:0] held_next;
    logic [PCT_W-1:0] cur;
    logic [PCT_W-1:0] step;
    logic [PCT_W-1:0] ramp_next;

    assign item_pop = item_avail && (!m_valid_reg || m_ready);
    assign tgt      = item.target_pct;

    always_comb begin
        diff = (tgt > held_level_reg) ? tgt - held_level_reg : held_level_reg - tgt;
        if (!hold_ready_reg || tgt == '0 || diff >= cfg.hyst_band) begin
            held_next = tgt;
        end else begin
            held_next = held_level_reg;
        end
    end

    always_comb begin
        cur = ramp_level_reg;
        priority if (cur == '0 && held_next != '0) begin
            step = cfg.step_on;
        end else if (held_next == '0 && cur != '0) begin
            step = cfg.step_off;
        end else begin
            step = cfg.ramp_step;
        end
        if (step == '0) begin
            step = PCT_W'(1);
        end
        priority if (!ramp_ready_reg) begin
            ramp_next = held_next;
        end else if (held_next > cur) begin
            ramp_next = ((held_next - cur) > step) ? cur + step : held_next;
        end else if (held_next < cur) begin
            ramp_next = ((cur - held_next) > step) ? cur - step : held_next;
        end else begin
            ramp_next = cur;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ready_reg <= 1'b0;
            held_level_reg <= '0;
            ramp_ready_reg <= 1'b0;
            ramp_level_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (item_pop) begin
                hold_ready_reg <= 1'b1;
                held_level_reg <= held_next;
                ramp_ready_reg <= 1'b1;
                ramp_level_reg <= ramp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            out_pct_reg    <= ramp_next;
            auto_pct_reg   <= item.auto_pct;
            target_pct_reg <= tgt;
            held_pct_reg   <= held_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_lamp_level   = out_pct_reg;
    assign m_auto_level   = auto_pct_reg;
    assign m_goal_level   = target_pct_reg;
    assign m_held_percent = held_pct_reg;

endmodule

[rtl/core/light_level_dimmer_ramp.sv]
// Top level of the dimmer ramp: front stage, queue, back stage and registers.
// The block takes one reading per cycle while the queue is not full and gives one
// result per reading. The front stage works out the automatic level and the gated
// target and writes them into a two-entry queue, and the back stage takes them from
// the queue, runs the hold and the ramp and loads the result register. The sustained
// rate of one transaction per cycle while results are taken is set by the back stage,
// whose held and ramp levels are fed back from one result to the next. The queue lets
// the input side keep accepting while a result waits to be taken, until it is full.
// Configuration writes are always accepted and take effect on the next cycle.
module light_level_dimmer_ramp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lldr_pkg::RAW_W-1:0]     s_light_raw,
    input  logic                           s_light_on,
    input  logic                           s_user_present,
    input  logic [lldr_pkg::OFS_W-1:0]     s_user_offset,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lldr_pkg::PCT_W-1:0]     m_lamp_level,
    output logic [lldr_pkg::PCT_W-1:0]     m_auto_level,
    output logic [lldr_pkg::PCT_W-1:0]     m_goal_level,
    output logic [lldr_pkg::PCT_W-1:0]     m_held_percent,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lldr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lldr_pkg::CFG_DAT_W-1:0] cfg_data
);
    import lldr_pkg::*;

    cfg_t         cfg;
    front_item_t  front_item;
    front_item_t  queue_item;
    fifo_status_t queue_status;
    logic         queue_pop;

    assign s_ready = !queue_status.full;

    lldr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lldr_front u_front (
        .light_raw    (s_light_raw),
        .light_on     (s_light_on),
        .user_present (s_user_present),
        .user_offset  (s_user_offset),
        .item         (front_item)
    );

    lldr_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_item),
        .pop       (queue_pop),
        .pop_data  (queue_item),
        .status    (queue_status)
    );

    lldr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .item           (queue_item),
        .item_avail     (!queue_status.empty),
        .item_pop       (queue_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lamp_level   (m_lamp_level),
        .m_auto_level   (m_auto_level),
        .m_goal_level   (m_goal_level),
        .m_held_percent (m_held_percent)
    );

endmodule

[rtl/core/lldr_checker.sv]
// Port-level assertions of the dimmer ramp and their binding to the top level.
`include "light_level_dimmer_ramp_assert.svh"

module lldr_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [lldr_pkg::PCT_W-1:0] m_lamp_level,
    input logic [lldr_pkg::PCT_W-1:0] m_auto_level,
    input logic [lldr_pkg::PCT_W-1:0] m_goal_level,
    input logic [lldr_pkg::PCT_W-1:0] m_held_percent
);
    import lldr_pkg::*;

    logic [4*PCT_W-1:0] res_bus;
    logic               stalled;
    logic               in_range;
    logic               zero_goal;

    assign res_bus   = {m_lamp_level, m_auto_level, m_goal_level, m_held_percent};
    assign stalled   = m_valid && !m_ready;
    assign in_range  = (m_lamp_level <= PCT_FULL) && (m_auto_level <= PCT_FULL)
                    && (m_goal_level <= PCT_FULL) && (m_held_percent <= PCT_FULL);
    assign zero_goal = m_valid && (m_goal_level == '0);

    `LLDR_ASSERT(a_held, stalled |=> (m_valid && $stable(res_bus)), "Stalled result changed.")
    `LLDR_ASSERT(a_range, m_valid |-> in_range, "A result lies above full scale.")
    `LLDR_ASSERT(a_zero_goal, zero_goal |-> (m_held_percent == '0), "Zero target not held.")
    `LLDR_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "Result offered after reset.")

endmodule

bind light_level_dimmer_ramp lldr_checker u_lldr_checker (.*);
